// ===== rtl/core/kfpi_pkg.sv =====
package kfpi_pkg;

    localparam int KEY_DEPTH  = 16;
    localparam int KB         = $clog2(KEY_DEPTH);
    localparam int KT_W       = KB + 1;
    localparam int WTB        = 10;
    localparam int TAB_SIZE   = 1 << WTB;
    localparam int PARAM_FRAC = 14;
    localparam int P_W        = KB + PARAM_FRAC;
    localparam int SH         = PARAM_FRAC - WTB + 1;
    localparam int W_W        = 17;
    localparam int FC_W       = 24;
    localparam int POSE_W     = 32;
    localparam int TIME_W     = 48;
    localparam int N_POSE     = 5;
    localparam int N_TIME     = 3;
    localparam int PROD_W     = W_W + POSE_W;
    localparam int SUM_W      = PROD_W + KB;
    localparam int WS_W       = W_W + KB;
    localparam int DNW        = SUM_W;
    localparam int DEN_W      = FC_W;
    localparam int CH_W       = 3;
    localparam int LP_W       = TIME_W + 16;

    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_FRAME = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PUSH, ST_EMPTY, ST_F_MUL, ST_F_DIV, ST_F_DIVW,
        ST_S_RD, ST_S_MUL, ST_S_ACC, ST_A_DIV, ST_A_DIVW,
        ST_L_A, ST_L_B, ST_L_C, ST_L_D, ST_CNT, ST_DONE
    } t_state;

    typedef struct packed {
        logic            capture;
        logic            push;
        logic            empty;
        logic            mul_cnt;
        logic            div_start;
        logic            div_avg;
        logic            param_zero;
        logic            param_load;
        logic [KB-1:0]   rd_addr;
        logic            scan_rd;
        logic            scan_mul;
        logic            scan_acc;
        logic            avg_load;
        logic [CH_W-1:0] ch;
        logic            lerp_a;
        logic            lerp_b;
        logic            lerp_sum;
        logic            cnt_adv;
    } t_cmd;

    typedef struct packed {
        logic [KT_W-1:0] keys;
        logic            fc_gt1;
        logic            div_done;
        logic [KB-1:0]   idx;
    } t_sts;

    typedef logic [W_W-1:0] t_wtab [TAB_SIZE];

    // exp(-y), y in Q31, answer in Q16: Taylor series then eight squarings
    function automatic logic [W_W-1:0] exp_q16(input logic [63:0] y);
        logic [63:0] z;
        logic [63:0] acc;
        z   = y >> 8;
        acc = 64'h8000_0000;
        acc = 64'h8000_0000 - (((z * acc) >> 31) / 5);
        acc = 64'h8000_0000 - (((z * acc) >> 31) / 4);
        acc = 64'h8000_0000 - (((z * acc) >> 31) / 3);
        acc = 64'h8000_0000 - (((z * acc) >> 31) / 2);
        acc = 64'h8000_0000 - ((z * acc) >> 31);
        for (int k = 0; k < 8; k++) begin
            acc = (acc * acc + (64'd1 << 30)) >> 31;
        end
        return W_W'((acc + 64'd16384) >> 15);
    endfunction

    function automatic t_wtab build_wtab();
        t_wtab t;
        logic [63:0] y;
        for (int i = 0; i < TAB_SIZE; i++) begin
            y = (64'd5 * 64'(i) * 64'(i)) << (31 - 2 * (WTB - 1));
            t[i] = exp_q16(y);
        end
        return t;
    endfunction

    localparam t_wtab W_TAB = build_wtab();

endpackage

// ===== rtl/core/kfpi_div.sv =====
module kfpi_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [kfpi_pkg::DNW-1:0]   i_num,
    input  logic [kfpi_pkg::DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic [kfpi_pkg::DNW-1:0]   o_quo
);
    import kfpi_pkg::*;

    localparam int CNT_W = $clog2(DNW + 1);

    logic [DNW-1:0]   r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {r_rem, r_q[DNW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DNW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
            r_q   <= {r_q[DNW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ===== rtl/core/kfpi_ctrl.sv =====
module kfpi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_kind,
    input  kfpi_pkg::t_sts i_sts,
    output kfpi_pkg::t_cmd o_cmd,
    output logic           o_busy,
    output logic           o_valid
);
    import kfpi_pkg::*;

    t_state        r_state, n_state;
    logic [KB-1:0] r_k, n_k;
    logic [CH_W-1:0] r_ch, n_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_ch    <= n_ch;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        n_ch          = r_ch;
        o_cmd         = '0;
        o_cmd.rd_addr = r_k;
        o_cmd.ch      = r_ch;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    case (t_kind'(i_kind))
                        KIND_PUSH:  n_state = ST_PUSH;
                        KIND_EMPTY: n_state = ST_EMPTY;
                        KIND_FRAME: n_state = ST_F_MUL;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = ST_DONE;
            end
            ST_EMPTY: begin
                o_cmd.empty = 1'b1;
                n_state     = ST_DONE;
            end
            ST_F_MUL: begin
                o_cmd.mul_cnt = 1'b1;
                n_state = (i_sts.keys < KT_W'(2)) ? ST_CNT : ST_F_DIV;
            end
            ST_F_DIV: begin
                n_k = '0;
                if (i_sts.fc_gt1) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_F_DIVW;
                end else begin
                    o_cmd.param_zero = 1'b1;
                    n_state          = ST_S_RD;
                end
            end
            ST_F_DIVW: begin
                if (i_sts.div_done) begin
                    o_cmd.param_load = 1'b1;
                    n_state          = ST_S_RD;
                end
            end
            ST_S_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = ST_S_MUL;
            end
            ST_S_MUL: begin
                o_cmd.scan_mul = 1'b1;
                n_state        = ST_S_ACC;
            end
            ST_S_ACC: begin
                o_cmd.scan_acc = 1'b1;
                if ({1'b0, r_k} == i_sts.keys - 1'b1) begin
                    n_ch    = '0;
                    n_state = ST_A_DIV;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_S_RD;
                end
            end
            ST_A_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_avg   = 1'b1;
                n_state         = ST_A_DIVW;
            end
            ST_A_DIVW: begin
                o_cmd.div_avg = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.avg_load = 1'b1;
                    if (r_ch == CH_W'(N_POSE - 1)) begin
                        n_state = ST_L_A;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = ST_A_DIV;
                    end
                end
            end
            ST_L_A: begin
                o_cmd.rd_addr = i_sts.idx;
                n_state       = ST_L_B;
            end
            ST_L_B: begin
                o_cmd.lerp_a  = 1'b1;
                o_cmd.rd_addr = i_sts.idx + 1'b1;
                n_state       = ST_L_C;
            end
            ST_L_C: begin
                o_cmd.lerp_b = 1'b1;
                n_state      = ST_L_D;
            end
            ST_L_D: begin
                o_cmd.lerp_sum = 1'b1;
                n_state        = ST_CNT;
            end
            ST_CNT: begin
                o_cmd.cnt_adv = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_DONE);

endmodule

// ===== rtl/core/kfpi_dp.sv =====
module kfpi_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kfpi_pkg::t_cmd                i_cmd,
    output kfpi_pkg::t_sts                o_sts,
    input  logic [kfpi_pkg::FC_W-1:0]     i_frame_count,
    input  logic signed [31:0]            i_lon,
    input  logic signed [31:0]            i_lat,
    input  logic signed [31:0]            i_alt,
    input  logic signed [31:0]            i_azm,
    input  logic signed [31:0]            i_gam,
    input  logic signed [47:0]            i_time_a,
    input  logic signed [47:0]            i_time_b,
    input  logic signed [47:0]            i_comb,
    output logic                          o_push_accepted,
    output logic signed [31:0]            o_out_lon,
    output logic signed [31:0]            o_out_lat,
    output logic signed [31:0]            o_out_alt,
    output logic signed [31:0]            o_out_azm,
    output logic signed [31:0]            o_out_gam,
    output logic signed [47:0]            o_out_time_a,
    output logic signed [47:0]            o_out_time_b,
    output logic signed [47:0]            o_out_comb,
    output logic                          o_path_ready,
    output logic                          o_last_frame
);
    import kfpi_pkg::*;

    localparam int PW_BITS = POSE_W * N_POSE;
    localparam int TW_BITS = TIME_W * N_TIME;

    logic [PW_BITS-1:0] pose_mem [KEY_DEPTH];
    logic [TW_BITS-1:0] time_mem [KEY_DEPTH];
    logic [PW_BITS-1:0] r_in_pose, r_rd_pose;
    logic [TW_BITS-1:0] r_in_time, r_rd_time;

    logic [KT_W-1:0]       r_keys;
    logic [FC_W-1:0]       r_counter;
    logic [FC_W+KB-1:0]    r_prod;
    logic [P_W-1:0]        r_param;
    logic [W_W-1:0]        r_w;
    logic [WS_W-1:0]       r_wsum;
    logic signed [PROD_W-1:0] r_p [N_POSE];
    logic signed [SUM_W-1:0]  r_s [N_POSE];
    logic signed [LP_W-1:0]   r_la [N_TIME];
    logic signed [LP_W-1:0]   r_lb [N_TIME];

    logic                   r_o_push;
    logic signed [POSE_W-1:0] r_o_pose [N_POSE];
    logic signed [TIME_W-1:0] r_o_time [N_TIME];
    logic                   r_o_ready;
    logic                   r_o_last;

    logic [DNW-1:0]   div_num, quo;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [SUM_W-1:0] mag;
    logic             neg;
    logic [P_W-1:0]   top, kp, d;
    logic [P_W:0]     ti;
    logic [KB-1:0]    pi, idx;
    logic [P_W-1:0]   f_full;
    logic [PARAM_FRAC:0] f, omf;
    logic [FC_W-1:0]  nxt;
    logic [KB-1:0]    keys_m1;

    kfpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    always_comb begin
        keys_m1 = KB'(r_keys - 1'b1);
        top     = {keys_m1, PARAM_FRAC'(0)};
        neg     = r_s[i_cmd.ch][SUM_W-1];
        mag     = neg ? SUM_W'(-r_s[i_cmd.ch]) : SUM_W'(r_s[i_cmd.ch]);
        if (i_cmd.div_avg) begin
            div_num = DNW'(mag + SUM_W'(r_wsum >> 1));
            div_den = DEN_W'(r_wsum);
        end else begin
            div_num = DNW'({r_prod, PARAM_FRAC'(0)});
            div_den = i_frame_count - 1'b1;
        end
        kp  = {i_cmd.rd_addr, PARAM_FRAC'(0)};
        d   = (r_param > kp) ? r_param - kp : kp - r_param;
        ti  = ({1'b0, d} + (P_W+1)'(1 << (SH - 1))) >> SH;
        pi  = r_param[P_W-1:PARAM_FRAC];
        idx = ({1'b0, pi} >= KT_W'(r_keys - 1'b1)) ? KB'(r_keys - 2'd2) : pi;
        f_full = r_param - {idx, PARAM_FRAC'(0)};
        f      = f_full[PARAM_FRAC:0];
        omf    = (PARAM_FRAC+1)'(1 << PARAM_FRAC) - f;
        nxt    = r_counter + 1'b1;
    end

    assign o_sts.keys     = r_keys;
    assign o_sts.fc_gt1   = (i_frame_count > FC_W'(1));
    assign o_sts.div_done = div_done;
    assign o_sts.idx      = idx;

    // key store: one write port at the fill count, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_keys < KT_W'(KEY_DEPTH))) begin
            pose_mem[r_keys[KB-1:0]] <= r_in_pose;
            time_mem[r_keys[KB-1:0]] <= r_in_time;
        end
        r_rd_pose <= pose_mem[i_cmd.rd_addr];
        r_rd_time <= time_mem[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys    <= '0;
            r_counter <= '0;
        end else begin
            if (i_cmd.push && (r_keys < KT_W'(KEY_DEPTH))) r_keys <= r_keys + 1'b1;
            if (i_cmd.empty) r_keys <= '0;
            if (i_cmd.cnt_adv) r_counter <= (nxt == i_frame_count) ? '0 : nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_pose <= {i_gam, i_azm, i_alt, i_lat, i_lon};
            r_in_time <= {i_comb, i_time_b, i_time_a};
            r_o_push  <= 1'b0;
            r_o_ready <= 1'b0;
            r_o_last  <= 1'b0;
            for (int c = 0; c < N_POSE; c++) r_o_pose[c] <= '0;
            for (int c = 0; c < N_TIME; c++) r_o_time[c] <= '0;
        end
        if (i_cmd.push) r_o_push <= (r_keys < KT_W'(KEY_DEPTH));
        if (i_cmd.mul_cnt) begin
            r_prod    <= r_counter * keys_m1;
            r_o_ready <= (i_frame_count != '0) && (r_keys >= KT_W'(2));
            r_wsum    <= '0;
            for (int c = 0; c < N_POSE; c++) r_s[c] <= '0;
        end
        if (i_cmd.param_zero) r_param <= '0;
        if (i_cmd.param_load) r_param <= (quo > DNW'(top)) ? top : quo[P_W-1:0];
        if (i_cmd.scan_rd) r_w <= (ti < (P_W+1)'(TAB_SIZE)) ? W_TAB[ti[WTB-1:0]] : '0;
        if (i_cmd.scan_mul) begin
            for (int c = 0; c < N_POSE; c++)
                r_p[c] <= PROD_W'($signed({1'b0, r_w}) *
                                  $signed(r_rd_pose[c*POSE_W +: POSE_W]));
        end
        if (i_cmd.scan_acc) begin
            r_wsum <= r_wsum + WS_W'(r_w);
            for (int c = 0; c < N_POSE; c++) r_s[c] <= r_s[c] + SUM_W'(r_p[c]);
        end
        if (i_cmd.avg_load) begin
            if (r_wsum == '0)
                r_o_pose[i_cmd.ch] <= '0;
            else if (neg)
                r_o_pose[i_cmd.ch] <= (quo > DNW'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                                 : -$signed(quo[31:0]);
            else
                r_o_pose[i_cmd.ch] <= (quo > DNW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                                 : $signed(quo[31:0]);
        end
        if (i_cmd.lerp_a) begin
            for (int c = 0; c < N_TIME; c++)
                r_la[c] <= LP_W'($signed(r_rd_time[c*TIME_W +: TIME_W]) *
                                 $signed({1'b0, omf}));
        end
        if (i_cmd.lerp_b) begin
            for (int c = 0; c < N_TIME; c++)
                r_lb[c] <= LP_W'($signed(r_rd_time[c*TIME_W +: TIME_W]) *
                                 $signed({1'b0, f}));
        end
        if (i_cmd.lerp_sum) begin
            for (int c = 0; c < N_TIME; c++)
                r_o_time[c] <= TIME_W'((r_la[c] + r_lb[c] +
                                        LP_W'(1 << (PARAM_FRAC - 1))) >>> PARAM_FRAC);
        end
        if (i_cmd.cnt_adv) r_o_last <= (nxt == i_frame_count);
    end

    assign o_push_accepted = r_o_push;
    assign o_out_lon    = r_o_pose[0];
    assign o_out_lat    = r_o_pose[1];
    assign o_out_alt    = r_o_pose[2];
    assign o_out_azm    = r_o_pose[3];
    assign o_out_gam    = r_o_pose[4];
    assign o_out_time_a = r_o_time[0];
    assign o_out_time_b = r_o_time[1];
    assign o_out_comb   = r_o_time[2];
    assign o_path_ready = r_o_ready;
    assign o_last_frame = r_o_last;

endmodule

// ===== rtl/core/keyframe_path_interpolator.sv =====
// Keyframe path interpolator. Raise start with an item while busy is low;
// the item is taken at that edge and busy stays high until its single result
// has been shown. The result is flagged by o_valid for exactly one cycle and
// cannot be held off, so capture it then. A push or store reset passes its
// own state and then the done state, an unknown kind goes straight to done,
// and a frame with fewer than two keys only advances the frame counter. A
// frame with two or more keys is set by the shared one-bit-per-cycle divider:
// when frame_count is above one it maps the frame counter to a path
// position, then each stored key is read, weighted and accumulated, and
// each of the five weighted pose sums is divided by the weight sum. The
// time lerp reads the two keys around the position and sums them weighted.
// pready is always high. frame_count is written over the APB port at byte
// address 0; the user must do so while the block is idle (not enforced).
module keyframe_path_interpolator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_lon,
    input  logic signed [31:0] i_lat,
    input  logic signed [31:0] i_alt,
    input  logic signed [31:0] i_azm,
    input  logic signed [31:0] i_gam,
    input  logic signed [47:0] i_time_a,
    input  logic signed [47:0] i_time_b,
    input  logic signed [47:0] i_comb,
    output logic               o_valid,
    output logic               o_push_accepted,
    output logic signed [31:0] o_out_lon,
    output logic signed [31:0] o_out_lat,
    output logic signed [31:0] o_out_alt,
    output logic signed [31:0] o_out_azm,
    output logic signed [31:0] o_out_gam,
    output logic signed [47:0] o_out_time_a,
    output logic signed [47:0] o_out_time_b,
    output logic signed [47:0] o_out_comb,
    output logic               o_path_ready,
    output logic               o_last_frame,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import kfpi_pkg::*;

    logic [FC_W-1:0] r_frame_count;
    t_cmd            cmd;
    t_sts            sts;

    // frame_count is the only register; upper address bit picks it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_frame_count <= pwdata[FC_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-FC_W){1'b0}}, r_frame_count};

    // sequence each item: decode kind; for a frame divide, scan keys, normalize, lerp
    kfpi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // key store, weight table, accumulators and result registers
    kfpi_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_frame_count   (r_frame_count),
        .i_lon           (i_lon),
        .i_lat           (i_lat),
        .i_alt           (i_alt),
        .i_azm           (i_azm),
        .i_gam           (i_gam),
        .i_time_a        (i_time_a),
        .i_time_b        (i_time_b),
        .i_comb          (i_comb),
        .o_push_accepted (o_push_accepted),
        .o_out_lon       (o_out_lon),
        .o_out_lat       (o_out_lat),
        .o_out_alt       (o_out_alt),
        .o_out_azm       (o_out_azm),
        .o_out_gam       (o_out_gam),
        .o_out_time_a    (o_out_time_a),
        .o_out_time_b    (o_out_time_b),
        .o_out_comb      (o_out_comb),
        .o_path_ready    (o_path_ready),
        .o_last_frame    (o_last_frame)
    );

    // a result only appears while its item still holds the block
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result strobe outside a busy item");

    // the block frees itself right after showing a result
    a_valid_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy) else $error("block still busy after result");

    // an accepted item holds the block on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid) || o_valid)
        else $error("accepted item did not occupy the block");

endmodule
